### design/mfs_pkg.sv
// Shared types and codes for the multilevel priority FIFO scheduler.
// No dependencies; every other design file except mfs_ram imports this package.
package mfs_pkg;

   // Operation codes of an input item
   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   // Result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // Fixed payload widths of the channels
   localparam int OP_W    = 1;
   localparam int ID_W    = 8;
   localparam int LEVEL_W = 3;
   localparam int STAT_W  = 2;

   // Command from the top level into the queue control
   typedef struct packed {
      logic               valid;
      logic [OP_W-1:0]    operation;
      logic [LEVEL_W-1:0] level;
   } cmd_type;

   // Outcome of one item as decided by the queue control
   typedef struct packed {
      logic               deq_ok;
      logic [STAT_W-1:0]  status;
      logic [LEVEL_W-1:0] served_level;
   } result_type;

endpackage

### design/mfs_if.sv
// Valid/ready channel interfaces for the scheduler's request and response items.
// Depends on mfs_pkg for the payload widths.
interface mfs_req_if import mfs_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    operation;
   logic [ID_W-1:0]    process_id;
   logic [LEVEL_W-1:0] level;

   modport source (output valid, output operation, output process_id, output level,
                   input ready);
   modport sink   (input valid, input operation, input process_id, input level,
                   output ready);
endinterface

interface mfs_rsp_if import mfs_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [STAT_W-1:0]  status;
   logic [ID_W-1:0]    served_id;
   logic [LEVEL_W-1:0] served_level;

   modport source (output valid, output status, output served_id, output served_level,
                   input ready);
   modport sink   (input valid, input status, input served_id, input served_level,
                   output ready);
endinterface

### design/mfs_ram.sv
// Generic single-port RAM with registered read data, held when no read is issued.
// No dependencies.
module mfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     write_en,
   input  logic                     read_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         write_data,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[addr] <= write_data;
      end
      if (read_en) begin
         read_data_ff <= mem_ff[addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

### design/mfs_ctrl.sv
// Queue control: per-level head/tail pointers and counts, priority select of the
// highest non-empty level, and entry memory address generation. Uses mfs_pkg.
module mfs_ctrl import mfs_pkg::*; #(
   parameter int NUM_LEVELS  = 8,
   parameter int LEVEL_DEPTH = 16,
   parameter int ADDR_BITS   = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output logic                 ram_write,
   output logic                 ram_read,
   output logic [ADDR_BITS-1:0] ram_addr,
   output result_type           result
);

   localparam int LVL_BITS = $clog2(NUM_LEVELS);
   localparam int PTR_BITS = $clog2(LEVEL_DEPTH);
   localparam int CNT_BITS = $clog2(LEVEL_DEPTH + 1);

   logic [PTR_BITS-1:0] head_ff  [NUM_LEVELS];
   logic [PTR_BITS-1:0] head_in  [NUM_LEVELS];
   logic [PTR_BITS-1:0] tail_ff  [NUM_LEVELS];
   logic [PTR_BITS-1:0] tail_in  [NUM_LEVELS];
   logic [CNT_BITS-1:0] count_ff [NUM_LEVELS];
   logic [CNT_BITS-1:0] count_in [NUM_LEVELS];

   logic                is_deq;
   logic                any_held;
   logic [LVL_BITS-1:0] top_lvl;
   logic [LVL_BITS-1:0] enq_lvl;
   logic [LVL_BITS-1:0] sel_lvl;
   logic                lvl_full;
   logic [PTR_BITS-1:0] ptr;
   logic [PTR_BITS-1:0] ptr_next;

   // Highest level holding at least one entry
   always_comb begin
      any_held = 1'b0;
      top_lvl  = '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
         if (count_ff[i] != '0) begin
            any_held = 1'b1;
            top_lvl  = LVL_BITS'(i);
         end
      end
   end

   // Enqueue level, saturated to the last level
   always_comb begin
      if (int'(cmd.level) >= NUM_LEVELS) begin
         enq_lvl = LVL_BITS'(NUM_LEVELS - 1);
      end else begin
         enq_lvl = LVL_BITS'(cmd.level);
      end
   end

   assign is_deq   = (cmd.operation == OP_DEQUEUE);
   assign lvl_full = (count_ff[enq_lvl] == CNT_BITS'(LEVEL_DEPTH));
   assign sel_lvl  = is_deq ? top_lvl : enq_lvl;
   assign ptr      = is_deq ? head_ff[sel_lvl] : tail_ff[sel_lvl];
   assign ptr_next = (ptr == PTR_BITS'(LEVEL_DEPTH - 1)) ? '0 : ptr + PTR_BITS'(1);

   // Memory access: dequeue reads the head entry, enqueue writes at the tail
   assign ram_write = cmd.valid && !is_deq && !lvl_full;
   assign ram_read  = cmd.valid && is_deq && any_held;
   assign ram_addr  = ADDR_BITS'(sel_lvl) * ADDR_BITS'(LEVEL_DEPTH) + ADDR_BITS'(ptr);

   // Pointer and count updates
   always_comb begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
         head_in[i]  = head_ff[i];
         tail_in[i]  = tail_ff[i];
         count_in[i] = count_ff[i];
      end
      if (ram_read) begin
         head_in[sel_lvl]  = ptr_next;
         count_in[sel_lvl] = count_ff[sel_lvl] - CNT_BITS'(1);
      end
      if (ram_write) begin
         tail_in[sel_lvl]  = ptr_next;
         count_in[sel_lvl] = count_ff[sel_lvl] + CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LEVELS; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < NUM_LEVELS; i++) begin
            head_ff[i]  <= head_in[i];
            tail_ff[i]  <= tail_in[i];
            count_ff[i] <= count_in[i];
         end
      end
   end

   // Item outcome
   always_comb begin
      result.deq_ok       = is_deq && any_held;
      result.served_level = result.deq_ok ? LEVEL_W'(top_lvl) : '0;
      if (is_deq) begin
         result.status = any_held ? ST_OK : ST_EMPTY;
      end else begin
         result.status = lvl_full ? ST_FULL : ST_OK;
      end
   end

endmodule

### design/multilevel_priority_fifo_scheduler_unit.sv
// Multilevel priority FIFO scheduler: NUM_LEVELS FIFOs of LEVEL_DEPTH process
// identifiers each, all held in one single-port entry memory. An enqueue item appends
// to its level's FIFO (status full if the level holds LEVEL_DEPTH entries); a dequeue
// item removes the oldest entry of the highest non-empty level (status empty if none).
// One item is accepted per clock unless the input stalls: pointers and counts update in
// the accept cycle and the one memory access per item is issued there, so the rate is
// set by that single memory port. The result moves from the memory stage into the output
// register once that register is free or being taken, and waits there until taken.
// While it waits, one more item can enter the memory stage; after that the input
// stalls until the result is taken. The memory needs no clearing pass after reset: an
// entry is only read while its level counts it as held.
module multilevel_priority_fifo_scheduler_unit import mfs_pkg::*; #(
   parameter int NUM_LEVELS  = 8,
   parameter int LEVEL_DEPTH = 16,
   parameter int ID_BITS     = 8
) (
   input  logic     clock,
   input  logic     reset,
   mfs_req_if.sink  req,
   mfs_rsp_if.source rsp
);

   localparam int ENTRIES   = NUM_LEVELS * LEVEL_DEPTH;
   localparam int ADDR_BITS = $clog2(ENTRIES);
   localparam int WIDE_BITS = (ID_BITS > ID_W) ? ID_BITS : ID_W;

   logic                 accept;
   logic                 out_load;
   cmd_type              cmd;
   result_type           result;
   logic                 ram_write;
   logic                 ram_read;
   logic [ADDR_BITS-1:0] ram_addr;
   logic [WIDE_BITS-1:0] pid_wide;
   logic [ID_BITS-1:0]   ram_rdata;
   logic [WIDE_BITS-1:0] rdata_wide;

   // Memory stage and output register
   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   result_type           s1_res_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [STAT_W-1:0]    rsp_status_ff;
   logic [ID_W-1:0]      rsp_id_ff;
   logic [LEVEL_W-1:0]   rsp_level_ff;

   assign out_load   = s1_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready  = !s1_valid_ff || out_load;
   assign accept     = req.valid && req.ready;

   assign cmd.valid     = accept;
   assign cmd.operation = req.operation;
   assign cmd.level     = req.level;

   mfs_ctrl #(
      .NUM_LEVELS  (NUM_LEVELS),
      .LEVEL_DEPTH (LEVEL_DEPTH),
      .ADDR_BITS   (ADDR_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .ram_write (ram_write),
      .ram_read  (ram_read),
      .ram_addr  (ram_addr),
      .result    (result)
   );

   // Identifier kept to its low ID_BITS bits
   assign pid_wide = WIDE_BITS'(req.process_id);

   mfs_ram #(
      .WIDTH (ID_BITS),
      .DEPTH (ENTRIES)
   ) u_entries (
      .clock      (clock),
      .write_en   (ram_write),
      .read_en    (ram_read),
      .addr       (ram_addr),
      .write_data (pid_wide[ID_BITS-1:0]),
      .read_data  (ram_rdata)
   );

   assign rdata_wide = WIDE_BITS'(ram_rdata);

   assign s1_valid_in  = accept || (s1_valid_ff && !out_load);
   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp.ready);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_res_ff <= result;
      end
      if (out_load) begin
         rsp_status_ff <= s1_res_ff.status;
         rsp_id_ff     <= s1_res_ff.deq_ok ? rdata_wide[ID_W-1:0] : '0;
         rsp_level_ff  <= s1_res_ff.served_level;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.served_id    = rsp_id_ff;
   assign rsp.served_level = rsp_level_ff;

endmodule

### design/mfs_checker.sv
// Port-level assertions for the scheduler, with the bind that attaches them.
// Depends on mfs_pkg and multilevel_priority_fifo_scheduler_unit.
module mfs_checker import mfs_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [STAT_W-1:0]  rsp_status,
   input logic [ID_W-1:0]    rsp_served_id,
   input logic [LEVEL_W-1:0] rsp_served_level
);

   // No result shows in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_served_id) && $stable(rsp_served_level))
      else $error("stalled result changed");

   // Only defined status codes come out
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_EMPTY
         || rsp_status == ST_FULL))
      else $error("undefined status code");

   // Empty and full results carry no identifier or level
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_served_id == '0 && rsp_served_level == '0)
      else $error("failed item carries a payload");

   // An item accepted after an idle pipe passes the memory stage and shows its result
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid && !$past(req_valid && req_ready)
         |=> ##1 rsp_valid)
      else $error("result missing after acceptance");

endmodule

bind multilevel_priority_fifo_scheduler_unit mfs_checker u_mfs_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_status       (rsp.status),
   .rsp_served_id    (rsp.served_id),
   .rsp_served_level (rsp.served_level)
);

### verif/tb_multilevel_priority_fifo_scheduler_unit.sv
// Self-checking testbench for the multilevel priority FIFO scheduler unit.
// Directed table, then random enqueue/dequeue traffic, each result checked against a predictor.
// Depends on mfs_pkg, the mfs_req_if/mfs_rsp_if interfaces and the scheduler top level.
module tb_multilevel_priority_fifo_scheduler_unit;
   import mfs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_LEVELS  = 8;
   localparam int LEVEL_DEPTH = 16;
   localparam int ID_BITS     = 8;
   localparam logic [ID_W-1:0] ID_MASK = ID_W'((1 << ID_BITS) - 1);

   localparam int RANDOM_PHASES  = 14;
   localparam int PHASE_ITEMS    = 100;
   localparam int HOLD_AT_RESULT = 200;   // result count at which the receiver holds off
   localparam int HOLD_CYCLES    = 300;
   localparam int STALL_LIMIT    = 4000;  // cycles with no item accepted on either side
   localparam int DRAIN_CYCLES   = 8;

   // One result item as seen on the response channel
   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [ID_W-1:0]    served_id;
      logic [LEVEL_W-1:0] served_level;
   } sched_rsp_type;

   // One row of the directed table; known rows carry a typed-in outcome
   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [ID_W-1:0]    process_id;
      logic [LEVEL_W-1:0] level;
      logic               known;
      sched_rsp_type      outcome;
   } sched_row_type;

   logic clock = 1'b0;
   logic reset;

   mfs_req_if req_ch ();
   mfs_rsp_if rsp_ch ();

   multilevel_priority_fifo_scheduler_unit #(
      .NUM_LEVELS  (NUM_LEVELS),
      .LEVEL_DEPTH (LEVEL_DEPTH),
      .ID_BITS     (ID_BITS)
   ) uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state: one FIFO per level
   logic [ID_W-1:0] entry_mem [NUM_LEVELS][LEVEL_DEPTH];
   int              head_ptr  [NUM_LEVELS];
   int              tail_ptr  [NUM_LEVELS];
   int              held      [NUM_LEVELS];

   sched_rsp_type pending_outcomes[$];
   sched_row_type directed_rows[$];

   int  error_count = 0;
   int  items_sent = 0;
   int  results_seen = 0;
   int  enqueues = 0;
   int  dequeues = 0;
   int  full_refusals = 0;
   int  empty_polls = 0;
   int  stall_cycles = 0;
   bit  send_burst = 1'b0;
   bit  recv_burst = 1'b0;

   // Append one row at the end of the directed table
   function automatic void append_row(sched_row_type row);
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   // Scheduler behavior for one accepted item; updates the predictor state
   function automatic sched_rsp_type schedule_item(logic [OP_W-1:0] op,
                                                   logic [ID_W-1:0] pid,
                                                   logic [LEVEL_W-1:0] lvl);
      sched_rsp_type outcome;
      int            target;
      outcome = '{ST_OK, '0, '0};
      if (op == OP_DEQUEUE) begin
         outcome.status = ST_EMPTY;
         for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
            if (outcome.status == ST_EMPTY && held[i] != 0) begin
               outcome.status       = ST_OK;
               outcome.served_id    = entry_mem[i][head_ptr[i]];
               outcome.served_level = LEVEL_W'(i);
               head_ptr[i]          = (head_ptr[i] + 1) % LEVEL_DEPTH;
               held[i]--;
            end
         end
      end else begin
         target = (int'(lvl) >= NUM_LEVELS) ? NUM_LEVELS - 1 : int'(lvl);
         if (held[target] >= LEVEL_DEPTH) begin
            outcome.status = ST_FULL;
         end else begin
            entry_mem[target][tail_ptr[target]] = pid & ID_MASK;
            tail_ptr[target] = (tail_ptr[target] + 1) % LEVEL_DEPTH;
            held[target]++;
         end
      end
      return outcome;
   endfunction

   // Offer one request item, wait for its acceptance and queue what it should return
   task automatic offer_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] pid,
                                input logic [LEVEL_W-1:0] lvl, input logic known,
                                input sched_rsp_type known_outcome);
      int            gap;
      sched_rsp_type outcome;
      gap = send_burst ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.operation  <= op;
      req_ch.process_id <= pid;
      req_ch.level      <= lvl;
      // ready is stable from the falling edge up to the next rising edge
      @(negedge clock);
      while (!req_ch.ready) @(negedge clock);
      @(posedge clock);
      outcome = schedule_item(op, pid, lvl);
      pending_outcomes.insert(pending_outcomes.size(), known ? known_outcome : outcome);
      items_sent++;
      if (op == OP_DEQUEUE) dequeues++;
      else enqueues++;
   endtask

   // Response side: random back-pressure, one long hold-off, field checks
   task automatic collect_results();
      int            gap;
      sched_rsp_type seen;
      sched_rsp_type want;
      forever begin
         if (results_seen % 64 == 0) recv_burst = ($urandom_range(0, 2) == 0);
         if (results_seen == HOLD_AT_RESULT) gap = HOLD_CYCLES;
         else gap = recv_burst ? 0 : $urandom_range(0, 9);
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(negedge clock);
         while (!rsp_ch.valid) @(negedge clock);
         seen = '{rsp_ch.status, rsp_ch.served_id, rsp_ch.served_level};
         if (pending_outcomes.size() == 0) begin
            $error("result item with nothing expected: status %0d id %0d level %0d",
                   seen.status, seen.served_id, seen.served_level);
            error_count++;
         end else begin
            want = pending_outcomes.pop_front();
            if (seen.status != want.status) begin
               $error("status: expected %0d, got %0d", want.status, seen.status);
               error_count++;
            end
            if (seen.served_id != want.served_id) begin
               $error("served_id: expected %0d, got %0d", want.served_id, seen.served_id);
               error_count++;
            end
            if (seen.served_level != want.served_level) begin
               $error("served_level: expected %0d, got %0d",
                      want.served_level, seen.served_level);
               error_count++;
            end
            if (want.status == ST_FULL) full_refusals++;
            if (want.status == ST_EMPTY) empty_polls++;
         end
         results_seen++;
         @(posedge clock);
      end
   endtask

   // Watchdog: too long with no item moving on either channel ends the run
   initial begin
      while (stall_cycles < STALL_LIMIT) begin
         @(negedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("watchdog: no item accepted for %0d cycles", STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      int               enq_pct;
      int               lvl_lo;
      int               lvl_hi;
      logic [OP_W-1:0]  op;
      logic [ID_W-1:0]  pid;
      sched_rsp_type    no_outcome;

      no_outcome = '{ST_OK, '0, '0};
      for (int i = 0; i < NUM_LEVELS; i++) begin
         head_ptr[i] = 0;
         tail_ptr[i] = 0;
         held[i]     = 0;
      end

      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.operation  <= OP_ENQUEUE;
      req_ch.process_id <= '0;
      req_ch.level      <= '0;
      rsp_ch.ready      <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      fork
         collect_results();
      join_none

      // Directed table: empty after reset, ignored fields on dequeue, extremes,
      // priority order, then one level filled to the brim and refused
      append_row('{OP_DEQUEUE, 8'h00, 3'd0, 1'b1, '{ST_EMPTY, 8'h00, 3'd0}});
      append_row('{OP_DEQUEUE, 8'hff, 3'd7, 1'b1, '{ST_EMPTY, 8'h00, 3'd0}});
      append_row('{OP_ENQUEUE, 8'hff, 3'd7, 1'b1, '{ST_OK, 8'h00, 3'd0}});
      append_row('{OP_ENQUEUE, 8'h00, 3'd0, 1'b1, '{ST_OK, 8'h00, 3'd0}});
      append_row('{OP_ENQUEUE, 8'h5a, 3'd3, 1'b0, no_outcome});
      append_row('{OP_DEQUEUE, 8'h00, 3'd0, 1'b1, '{ST_OK, 8'hff, 3'd7}});
      append_row('{OP_DEQUEUE, 8'ha5, 3'd5, 1'b0, no_outcome});
      append_row('{OP_DEQUEUE, 8'h00, 3'd0, 1'b1, '{ST_OK, 8'h00, 3'd0}});
      append_row('{OP_DEQUEUE, 8'h00, 3'd0, 1'b1, '{ST_EMPTY, 8'h00, 3'd0}});
      for (int i = 0; i < LEVEL_DEPTH; i++)
         append_row('{OP_ENQUEUE, ID_W'(8'h11 * i), 3'd7, 1'b0, no_outcome});
      append_row('{OP_ENQUEUE, 8'h42, 3'd7, 1'b1, '{ST_FULL, 8'h00, 3'd0}});

      foreach (directed_rows[r])
         offer_request(directed_rows[r].operation, directed_rows[r].process_id,
                       directed_rows[r].level, directed_rows[r].known,
                       directed_rows[r].outcome);

      // Random phases: enqueue bias and level span vary so levels fill, wrap and drain
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case ($urandom_range(0, 3))
            0: enq_pct = 15;
            1: enq_pct = 50;
            2: enq_pct = 85;
            default: enq_pct = 97;
         endcase
         if ($urandom_range(0, 1) == 0) begin
            lvl_lo = 0;
            lvl_hi = NUM_LEVELS - 1;
         end else begin
            lvl_lo = $urandom_range(0, NUM_LEVELS - 1);
            lvl_hi = $urandom_range(lvl_lo, NUM_LEVELS - 1);
         end
         send_burst = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            op  = ($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
            pid = ID_W'($urandom_range(0, 255));
            offer_request(op, pid, LEVEL_W'($urandom_range(lvl_lo, lvl_hi)), 1'b0,
                          no_outcome);
         end
      end
      req_ch.valid <= 1'b0;

      // Drain, then give the pipeline time to show any stray result
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d items: %0d enqueues, %0d dequeues, %0d results checked",
               items_sent, enqueues, dequeues, results_seen);
      $display("refused on full level: %0d, dequeues on empty scheduler: %0d",
               full_refusals, empty_polls);
      if (error_count == 0 && pending_outcomes.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

### multilevel_priority_fifo_scheduler_unit.f
design/mfs_pkg.sv
design/mfs_if.sv
design/mfs_ram.sv
design/mfs_ctrl.sv
design/multilevel_priority_fifo_scheduler_unit.sv
design/mfs_checker.sv
verif/tb_multilevel_priority_fifo_scheduler_unit.sv
